// ===== src/dtg_pkg.sv =====
// dtg_pkg: widths, register indexes, reset values and scaling constants
// for the debounced toggle tone gate; no dependencies
package dtg_pkg;

    // payload widths fixed by the item format
    localparam int CHAN_W  = 3;
    localparam int PITCH_W = 11;

    // configuration register widths
    localparam int LIMIT_W    = 10;
    localparam int MASK_W     = 6;
    localparam int CUT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT        = 2'd2;

    // configuration reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;
    localparam logic [MASK_W-1:0]  MASK_RESET  = 6'd0;
    localparam logic [CUT_W-1:0]   CUT_RESET   = 11'd10;

    // pitch = sample * 1000 / 512, saturated to the pitch field
    localparam int SCALE_MUL   = 1000;
    localparam int SCALE_SHIFT = 9;
    localparam int SCALE_MUL_W = 10;
    localparam logic [PITCH_W-1:0] PITCH_MAX = 11'd2047;

    // per-channel debounce and hold state
    typedef struct packed {
        logic [LIMIT_W-1:0] cnt;
        logic               released;
        logic               prev_pressed;
        logic               hold;
    } t_chan_state;

endpackage

// ===== src/dtg_in_if.sv =====
// dtg_in_if: scan request channel (valid/ready plus one channel scan)
// depends on dtg_pkg for the channel field width
interface dtg_in_if #(
    parameter int SAMPLE_BITS = 10
);
    import dtg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CHAN_W-1:0]      chan;
    logic                   pin_level;
    logic [SAMPLE_BITS-1:0] knob_sample;

    modport source (output valid, output chan, output pin_level, output knob_sample,
                    input ready);
    modport sink   (input valid, input chan, input pin_level, input knob_sample,
                    output ready);
endinterface

// ===== src/dtg_out_if.sv =====
// dtg_out_if: gated pitch request channel (valid/ready plus result fields)
// depends on dtg_pkg for the field widths
interface dtg_out_if;
    import dtg_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  out_chan;
    logic [PITCH_W-1:0] pitch;
    logic               held;

    modport source (output valid, output out_chan, output pitch, output held,
                    input ready);
    modport sink   (input valid, input out_chan, input pitch, input held,
                    output ready);
endinterface

// ===== src/debounced_toggle_tone_gate_core.sv =====
// debounced_toggle_tone_gate_core: scan register, pitch scaling, per-channel
// debounce/toggle state and result register; depends on dtg_pkg, dtg_in_if, dtg_out_if
//
//   channel  | dir | contents
//   ---------+-----+------------------------------------------------
//   i_in     | in  | chan, pin_level, knob_sample (valid/ready)
//   o_out    | out | out_chan, pitch, held (valid/ready)
//   i_cfg_*  | in  | write enable, register index, write data
//
// one request per cycle sustained while o_out is not stalled; a request reaches
// o_out.valid through the scan register, then the result register
// the state update (toggle-mode channels only) and the result are produced in the same cycle, so
// back-to-back scans of one channel see each other's state
// a stalled o_out holds both stages; i_in.ready drops only when both are full
// synchronous active-low reset restores valid flags, configuration registers and per-channel state
module debounced_toggle_tone_gate_core #(
    parameter int NUM_CHANNELS = 6,
    parameter int SAMPLE_BITS  = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dtg_in_if.sink                           i_in,
    dtg_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [dtg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dtg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dtg_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + SCALE_MUL_W;

    // configuration registers
    logic [LIMIT_W-1:0] r_limit;
    logic [MASK_W-1:0]  r_mask;
    logic [CUT_W-1:0]   r_cut;

    // scan register
    logic                   r_s1_valid;
    logic [CHAN_W-1:0]      r_s1_chan;
    logic                   r_s1_pin;
    logic [SAMPLE_BITS-1:0] r_s1_knob;

    // result register
    logic               r_out_valid;
    logic [CHAN_W-1:0]  r_out_chan;
    logic [PITCH_W-1:0] r_out_pitch;
    logic               r_out_held;

    // per-channel state
    t_chan_state r_state [NUM_CHANNELS];
    t_chan_state n_state;

    logic               w_advance;
    logic               w_in_range;
    logic               w_toggle;
    t_chan_state        w_cur;
    logic [PROD_W-1:0]  w_prod;
    logic [31:0]        w_scaled;
    logic [PITCH_W-1:0] w_pitch_sat;
    logic [PITCH_W-1:0] w_pitch_cut;
    logic [LIMIT_W-1:0] w_cnt;
    logic               w_pressed;
    logic [PITCH_W-1:0] n_pitch;
    logic               n_held;

    // handshake: the result register frees up when empty or taken
    assign w_advance  = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_mask  <= MASK_RESET;
            r_cut   <= CUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_TOGGLE_MASK:    r_mask  <= i_cfg_data[MASK_W-1:0];
                REG_LOW_CUT:        r_cut   <= i_cfg_data[CUT_W-1:0];
                default: ;
            endcase
        end
    end

    // scan register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_chan <= i_in.chan;
            r_s1_pin  <= i_in.pin_level;
            r_s1_knob <= i_in.knob_sample;
        end
    end

    // channel select and state read
    always_comb begin
        w_in_range = int'(r_s1_chan) < NUM_CHANNELS;
        w_toggle   = 1'b0;
        for (int m = 0; m < MASK_W; m++) begin
            if (int'(r_s1_chan) == m && m < NUM_CHANNELS) begin
                w_toggle = r_mask[m];
            end
        end
        w_cur = '{cnt: '0, released: 1'b1, prev_pressed: 1'b1, hold: 1'b0};
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (int'(r_s1_chan) == c) begin
                w_cur = r_state[c];
            end
        end
    end

    // pitch scaling, saturation and low cut
    always_comb begin
        w_prod   = PROD_W'(r_s1_knob) * PROD_W'(SCALE_MUL);
        w_scaled = 32'(w_prod >> SCALE_SHIFT);
        if (w_scaled > 32'(PITCH_MAX)) begin
            w_pitch_sat = PITCH_MAX;
        end else begin
            w_pitch_sat = w_scaled[PITCH_W-1:0];
        end
        w_pitch_cut = (w_pitch_sat < r_cut) ? '0 : w_pitch_sat;
    end

    // integrator debounce and hold toggle
    always_comb begin
        w_cnt   = w_cur.cnt;
        n_state = w_cur;
        if (!r_s1_pin) begin
            if (w_cnt != '0) begin
                w_cnt = w_cnt - 1'b1;
            end
        end else if (w_cnt < r_limit) begin
            w_cnt = w_cnt + 1'b1;
        end
        if (w_cnt == '0) begin
            n_state.released = 1'b0;
        end else if (w_cnt >= r_limit) begin
            w_cnt            = r_limit;
            n_state.released = 1'b1;
        end
        n_state.cnt          = w_cnt;
        w_pressed            = !n_state.released;
        n_state.hold         = w_cur.hold ^ (w_pressed && !w_cur.prev_pressed);
        n_state.prev_pressed = w_pressed;
    end

    // gate and held flag
    always_comb begin
        n_pitch = '0;
        n_held  = 1'b0;
        if (w_in_range) begin
            if (w_toggle) begin
                n_pitch = n_state.hold ? w_pitch_cut : '0;
                n_held  = n_state.hold;
            end else begin
                n_pitch = r_s1_pin ? '0 : w_pitch_cut;
                n_held  = w_cur.hold;
            end
        end
    end

    // per-channel state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_state[c] <= '{cnt: '0, released: 1'b1, prev_pressed: 1'b1, hold: 1'b0};
            end
        end else if (r_s1_valid && w_advance && w_in_range && w_toggle) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (int'(r_s1_chan) == c) begin
                    r_state[c] <= n_state;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_s1_valid) begin
            r_out_chan  <= r_s1_chan;
            r_out_pitch <= n_pitch;
            r_out_held  <= n_held;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_chan = r_out_chan;
    assign o_out.pitch    = r_out_pitch;
    assign o_out.held     = r_out_held;

endmodule

// ===== src/dtg_checker.sv =====
// dtg_checker: port-level assertions for the tone gate core
// depends on dtg_pkg; bound to debounced_toggle_tone_gate_core below
module dtg_checker #(
    parameter int NUM_CHANNELS = 6
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [dtg_pkg::CHAN_W-1:0]   i_out_chan,
    input logic [dtg_pkg::PITCH_W-1:0]  i_out_pitch,
    input logic                         i_out_held
);
    import dtg_pkg::*;

    // a stalled result keeps its request
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_chan) && $stable(i_out_pitch) && $stable(i_out_held))
        else $error("result payload changed while stalled");

    // unknown channels are silent and never held
    a_out_of_range_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && int'(i_out_chan) >= NUM_CHANNELS |->
            i_out_pitch == '0 && !i_out_held)
        else $error("out of range channel produced pitch or hold");

    // with the result register empty the scan side must be open
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("scan side blocked with empty result register");

endmodule

bind debounced_toggle_tone_gate_core dtg_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_dtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_chan  (o_out.out_chan),
    .i_out_pitch (o_out.pitch),
    .i_out_held  (o_out.held)
);
